// ----- rtl/core/srag_pkg.sv -----
// ----------------------------------------------------------------------------
// Strip rotate address generator package
// Shared constants, register codes, types and helpers for the rotation block.
// ----------------------------------------------------------------------------
package srag_pkg;

	localparam int STRIP_WIDTH     = 48;
	localparam int PORTRAIT_WIDTH  = 320;
	localparam int LANDSCAPE_WIDTH = 480;

	localparam int PIX_W     = 16;
	localparam int ADDR_W    = 14;
	localparam int COL_W     = 9;
	localparam int OFF_W     = 6;
	localparam int ROW_W     = 9;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [COL_W-1:0] COL_MAX        = COL_W'(LANDSCAPE_WIDTH - 1);
	localparam logic [COL_W-1:0] FIRST_COL_RST  = '0;
	localparam logic [COL_W-1:0] LAST_COL_RST   = COL_W'(LANDSCAPE_WIDTH - 1);

	typedef enum logic {
		REG_FIRST_COL = 1'b0,
		REG_LAST_COL  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [COL_W-1:0] first;
		logic [COL_W-1:0] last;
		logic             restart;
	} cfg_ctrl_t;

	function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
		return (c > COL_MAX) ? COL_MAX : c;
	endfunction

endpackage

// ----- rtl/core/srag_in_if.sv -----
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one landscape pixel per word.
// ----------------------------------------------------------------------------
interface srag_in_if
	import srag_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

// ----- rtl/core/srag_out_if.sv -----
// ----------------------------------------------------------------------------
// Rotated pixel output channel
// Valid/ready channel carrying a pixel with its strip buffer address and marks.
// ----------------------------------------------------------------------------
interface srag_out_if
	import srag_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  pixel_out;
	logic [ADDR_W-1:0] write_address;
	logic [COL_W-1:0]  strip_first_col;
	logic [OFF_W-1:0]  strip_width_out;
	logic              strip_done;
	logic              area_done;

	modport source (output valid, output pixel_out, output write_address,
		output strip_first_col, output strip_width_out, output strip_done,
		output area_done, input ready);
	modport sink (input valid, input pixel_out, input write_address,
		input strip_first_col, input strip_width_out, input strip_done,
		input area_done, output ready);
endinterface

// ----- rtl/core/strip_rotate_address_gen_top.sv -----
// ----------------------------------------------------------------------------
// Strip rotate address generator, top level
// Turns a landscape pixel stream into portrait strip buffer write words.
// ----------------------------------------------------------------------------
// Pixels enter on the pix_in channel in strip order: row 0 to 319 and, within
// a row, column offset 0 to width-1. Each pixel leaves on the rot_out channel
// with its strip buffer address, the strip's first column and width, and the
// end-of-strip and end-of-area marks. One word leaves for every word taken.
// The area's first and last columns are set through the APB port at byte
// addresses 0 and 4; a write restarts the traversal at the first column and
// should only be done while no word is in flight.
// An accepted pixel passes through one input register and one result register,
// with short address logic between them, before its word is offered.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single traversal update that each pixel makes to the column, row and
// strip counters.
// Reset clears the counters, sets the area to columns 0 to 479 and empties
// both registers. When the receiver stalls, the result register and then the
// input register hold their words and pix_in.ready drops only when both are full.
// ----------------------------------------------------------------------------
module strip_rotate_address_gen_top
	import srag_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	srag_in_if.sink            pix_in,
	srag_out_if.source         rot_out
);

	cfg_ctrl_t cfg;

	srag_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srag_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (pix_in),
		.out_ch (rot_out)
	);

endmodule

// ----- rtl/core/srag_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file for the area columns, with saturation and restart pulse.
// ----------------------------------------------------------------------------
module srag_cfg
	import srag_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_ctrl_t          cfg
);

	logic [COL_W-1:0] first_col_q;
	logic [COL_W-1:0] last_col_q;
	logic             restart_q;
	logic             wr_en;
	reg_idx_t         reg_idx;
	logic [COL_W-1:0] first_eff;
	logic [COL_W-1:0] last_clamp;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_col_q <= FIRST_COL_RST;
			last_col_q  <= LAST_COL_RST;
			restart_q   <= 1'b0;
		end else begin
			restart_q <= wr_en;
			if (wr_en) begin
				unique case (reg_idx)
					REG_FIRST_COL: first_col_q <= pwdata[COL_W-1:0];
					REG_LAST_COL:  last_col_q  <= pwdata[COL_W-1:0];
					default:       first_col_q <= first_col_q;
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FIRST_COL: prdata = PDATA_W'(first_col_q);
			REG_LAST_COL:  prdata = PDATA_W'(last_col_q);
			default:       prdata = '0;
		endcase
	end

	assign first_eff   = clamp_col(first_col_q);
	assign last_clamp  = clamp_col(last_col_q);
	assign cfg.first   = first_eff;
	assign cfg.last    = (last_clamp < first_eff) ? first_eff : last_clamp;
	assign cfg.restart = restart_q;

endmodule

// ----- rtl/core/srag_core.sv -----
// ----------------------------------------------------------------------------
// Strip traversal and address core
// Input register, traversal counters, address logic and result register.
// ----------------------------------------------------------------------------
module srag_core
	import srag_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_ctrl_t         cfg,
	srag_in_if.sink           in_ch,
	srag_out_if.source        out_ch
);

	logic              valid_s1;
	logic [PIX_W-1:0]  pixel_s1;

	logic              valid_s2;
	logic [PIX_W-1:0]  pixel_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [COL_W-1:0]  first_col_s2;
	logic [OFF_W-1:0]  width_s2;
	logic              sdone_s2;
	logic              adone_s2;

	logic [COL_W-1:0]  strip_start_q;
	logic [OFF_W-1:0]  col_offset_q;
	logic [ROW_W-1:0]  row_index_q;

	logic              adv_s2;
	logic              take_s1;

	logic              out_of_area;
	logic [COL_W-1:0]  ss0;
	logic [OFF_W-1:0]  off0;
	logic [ROW_W-1:0]  row0;
	logic [COL_W:0]    span0;
	logic [COL_W:0]    span_f;
	logic [OFF_W-1:0]  width0;
	logic [OFF_W-1:0]  width_f;
	logic              bad_pos;
	logic [COL_W-1:0]  ss1;
	logic [OFF_W-1:0]  off1;
	logic [ROW_W-1:0]  row1;
	logic [OFF_W-1:0]  width1;
	logic [ADDR_W-1:0] addr;
	logic [OFF_W:0]    off_inc;
	logic [ROW_W:0]    row_inc;
	logic [COL_W:0]    ss_sum;
	logic              row_wrap;
	logic              strip_wrap;
	logic              area_wrap;
	logic [COL_W-1:0]  ss_next;
	logic [OFF_W-1:0]  off_next;
	logic [ROW_W-1:0]  row_next;

	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv_s2;
	assign take_s1     = valid_s1 && adv_s2;

	always_comb begin
		out_of_area = (strip_start_q < cfg.first) || (strip_start_q > cfg.last);
		ss0  = out_of_area ? cfg.first : strip_start_q;
		off0 = out_of_area ? '0 : col_offset_q;
		row0 = out_of_area ? '0 : row_index_q;

		span0  = {1'b0, cfg.last} - {1'b0, ss0} + (COL_W+1)'(1);
		width0 = (span0 > (COL_W+1)'(STRIP_WIDTH)) ? OFF_W'(STRIP_WIDTH) : span0[OFF_W-1:0];
		span_f = {1'b0, cfg.last} - {1'b0, cfg.first} + (COL_W+1)'(1);
		width_f = (span_f > (COL_W+1)'(STRIP_WIDTH)) ? OFF_W'(STRIP_WIDTH) : span_f[OFF_W-1:0];

		bad_pos = (off0 >= width0) || (row0 >= ROW_W'(PORTRAIT_WIDTH));
		ss1    = bad_pos ? cfg.first : ss0;
		off1   = bad_pos ? '0 : off0;
		row1   = bad_pos ? '0 : row0;
		width1 = bad_pos ? width_f : width0;

		addr = ADDR_W'(ADDR_W'(off1) * ADDR_W'(PORTRAIT_WIDTH))
			+ ADDR_W'(PORTRAIT_WIDTH - 1) - ADDR_W'(row1);

		off_inc    = {1'b0, off1} + (OFF_W+1)'(1);
		row_wrap   = off_inc >= {1'b0, width1};
		row_inc    = {1'b0, row1} + (ROW_W+1)'(1);
		strip_wrap = row_wrap && (row_inc >= (ROW_W+1)'(PORTRAIT_WIDTH));
		ss_sum     = {1'b0, ss1} + (COL_W+1)'(width1);
		area_wrap  = strip_wrap && (ss_sum > {1'b0, cfg.last});

		off_next = row_wrap ? '0 : off_inc[OFF_W-1:0];
		row_next = strip_wrap ? '0 : (row_wrap ? row_inc[ROW_W-1:0] : row1);
		ss_next  = area_wrap ? cfg.first : (strip_wrap ? ss_sum[COL_W-1:0] : ss1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_start_q <= '0;
			col_offset_q  <= '0;
			row_index_q   <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			if (cfg.restart) begin
				strip_start_q <= cfg.first;
				col_offset_q  <= '0;
				row_index_q   <= '0;
			end else if (take_s1) begin
				strip_start_q <= ss_next;
				col_offset_q  <= off_next;
				row_index_q   <= row_next;
			end
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			pixel_s1 <= in_ch.pixel_in;
		end
		if (take_s1) begin
			pixel_s2     <= pixel_s1;
			addr_s2      <= addr;
			first_col_s2 <= ss1;
			width_s2     <= width1;
			sdone_s2     <= strip_wrap;
			adone_s2     <= area_wrap;
		end
	end

	assign out_ch.valid           = valid_s2;
	assign out_ch.pixel_out       = pixel_s2;
	assign out_ch.write_address   = addr_s2;
	assign out_ch.strip_first_col = first_col_s2;
	assign out_ch.strip_width_out = width_s2;
	assign out_ch.strip_done      = sdone_s2;
	assign out_ch.area_done       = adone_s2;

`ifndef SYNTH
	a_off_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_offset_q < OFF_W'(STRIP_WIDTH))
		else $error("column offset left the strip");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_index_q < ROW_W'(PORTRAIT_WIDTH))
		else $error("row index left the portrait height");

	a_area_with_strip: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && adone_s2 |-> sdone_s2)
		else $error("area end without strip end");

	a_addr_in_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> addr_s2 < ADDR_W'(STRIP_WIDTH * PORTRAIT_WIDTH))
		else $error("write address beyond strip buffer");
`endif

endmodule
